[hw/rtl/hwgrb_pkg.sv]
// Package for the hue wheel GRB bit serializer.
// Holds field widths, mode and brightness codes, and color wheel constants.
// No dependencies; used by hwgrb_if.sv and the core.
package hwgrb_pkg;

  localparam int CHAN_W     = 8;
  localparam int BRT_W      = 2;
  localparam int PIXEL_BITS = 3 * CHAN_W;
  localparam int BIT_IDX_W  = $clog2(PIXEL_BITS);

  typedef logic [CHAN_W-1:0]    chan_t;
  typedef logic [BRT_W-1:0]     brt_t;
  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [BIT_IDX_W-1:0] bit_idx_t;

  // Item modes
  localparam logic MODE_RAW = 1'b0;
  localparam logic MODE_HUE = 1'b1;

  // Brightness levels
  localparam brt_t BRT_DIV6  = 2'd0;
  localparam brt_t BRT_DIV3  = 2'd1;
  localparam brt_t BRT_UNITY = 2'd2;
  localparam brt_t BRT_X3    = 2'd3;

  // Color wheel segment bounds
  localparam chan_t WHEEL_SEG1_MAX  = 8'd85;
  localparam chan_t WHEEL_SEG2_BASE = 8'd86;
  localparam chan_t WHEEL_SEG2_MAX  = 8'd170;
  localparam chan_t WHEEL_SEG3_BASE = 8'd171;
  localparam chan_t CHAN_MAX        = 8'd255;

  // Divide by three: (v * 171) >> 9 is exact for every 8-bit v
  localparam int                DIV3_PROD_W = 2 * CHAN_W;
  localparam logic [DIV3_PROD_W-1:0] DIV3_RECIP = 16'd171;
  localparam int                DIV3_SHIFT  = 9;

  localparam bit_idx_t LAST_BIT_IDX = bit_idx_t'(PIXEL_BITS - 1);

endpackage

[hw/rtl/hwgrb_if.sv]
// Valid/ready channel interfaces for the hue wheel GRB bit serializer.
// hwgrb_pixel_if carries one pixel request, hwgrb_bit_if one serial bit.
// Depends on hwgrb_pkg for field widths.
interface hwgrb_pixel_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  hwgrb_pkg::chan_t     green_in;
  hwgrb_pkg::chan_t     red_in;
  hwgrb_pkg::chan_t     blue_in;
  hwgrb_pkg::chan_t     hue;
  hwgrb_pkg::brt_t      brightness;

  modport source (output valid, mode, green_in, red_in, blue_in, hue, brightness,
                  input ready);
  modport sink   (input valid, mode, green_in, red_in, blue_in, hue, brightness,
                  output ready);
endinterface

interface hwgrb_bit_if;
  logic valid;
  logic ready;
  logic bit_value;
  logic last;

  modport source (output valid, bit_value, last, input ready);
  modport sink   (input valid, bit_value, last, output ready);
endinterface

[hw/rtl/hue_wheel_grb_bit_serializer_core.sv]
// Hue wheel GRB bit serializer core: color conversion and 24-bit output shifter.
// Depends on hwgrb_pkg and the channel interfaces in hwgrb_if.sv.

// Each pixel transaction on in_ch yields 24 bit transactions on out_ch, most
// significant bit first, green then red then blue, with last set on the 24th.
// A pixel is either raw (mode 0: green_in, red_in, blue_in as given) or taken
// from a three-segment color wheel (mode 1: hue, then brightness divides each
// channel by 6 or 3, keeps it, or multiplies it by 3). The pixel rate is set
// by the output shifter, which moves one bit per cycle while out_ch.ready is
// high. One pixel transaction waits in the input register while the shifter
// drains the previous one, and the shifter reloads in the cycle after its last
// bit goes out, so a source that keeps in_ch.valid high and a sink that keeps
// out_ch.ready high see an unbroken bit stream. A pixel accepted while the
// shifter is free is held in the input register, then loaded into the shifter.
// There is no configuration and no state beyond the pipeline itself.
module hue_wheel_grb_bit_serializer_core (
  input  logic            clk,
  input  logic            rst_n,
  hwgrb_pixel_if.sink     in_ch,
  hwgrb_bit_if.source     out_ch
);

  // Scale one wheel channel (value 0..85) by the brightness level.
  function automatic hwgrb_pkg::chan_t scale_chan(input hwgrb_pkg::chan_t v,
                                                  input hwgrb_pkg::brt_t lvl);
    logic [hwgrb_pkg::DIV3_PROD_W-1:0] prod;
    hwgrb_pkg::chan_t                  third;
    hwgrb_pkg::chan_t                  res;
    prod  = {{(hwgrb_pkg::DIV3_PROD_W - hwgrb_pkg::CHAN_W){1'b0}}, v}
            * hwgrb_pkg::DIV3_RECIP;
    third = hwgrb_pkg::chan_t'(prod >> hwgrb_pkg::DIV3_SHIFT);
    case (lvl)
      hwgrb_pkg::BRT_DIV6:  res = third >> 1;
      hwgrb_pkg::BRT_DIV3:  res = third;
      hwgrb_pkg::BRT_UNITY: res = v;
      hwgrb_pkg::BRT_X3:    res = hwgrb_pkg::chan_t'({v, 1'b0} + {1'b0, v});
      default:              res = v;
    endcase
    return res;
  endfunction

  // Input register: one pending pixel transaction
  logic              pend_vld_r,  pend_vld_nxt;
  logic              pend_mode_r;
  hwgrb_pkg::chan_t  pend_g_r, pend_r_r, pend_b_r, pend_hue_r;
  hwgrb_pkg::brt_t   pend_brt_r;

  // Output shifter
  logic                  out_vld_r,  out_vld_nxt;
  hwgrb_pkg::pixel_t     shift_r,    shift_nxt;
  hwgrb_pkg::bit_idx_t   idx_r,      idx_nxt;

  logic              in_take;
  logic              out_take;
  logic              shift_done;
  logic              load;

  hwgrb_pkg::chan_t  wheel_g, wheel_r, wheel_b;
  hwgrb_pkg::chan_t  pix_g, pix_r, pix_b;

  assign in_take    = in_ch.valid && in_ch.ready;
  assign out_take   = out_vld_r && out_ch.ready;
  assign shift_done = out_take && (idx_r == hwgrb_pkg::LAST_BIT_IDX);
  // Reload the shifter when it is empty or its last bit leaves this cycle
  assign load       = pend_vld_r && (!out_vld_r || shift_done);

  // Accept a new pixel whenever the pending slot is free or drains now
  assign in_ch.ready = !pend_vld_r || load;

  // Color wheel: pick segment, then blend two channels linearly
  always_comb begin
    wheel_g = '0;
    wheel_r = '0;
    wheel_b = '0;
    if (pend_hue_r <= hwgrb_pkg::WHEEL_SEG1_MAX) begin
      wheel_r = pend_hue_r;
      wheel_b = hwgrb_pkg::WHEEL_SEG1_MAX - pend_hue_r;
    end else if (pend_hue_r > hwgrb_pkg::WHEEL_SEG2_MAX) begin
      wheel_g = hwgrb_pkg::CHAN_MAX - pend_hue_r;
      wheel_b = pend_hue_r - hwgrb_pkg::WHEEL_SEG3_BASE;
    end else begin
      wheel_g = pend_hue_r - hwgrb_pkg::WHEEL_SEG2_BASE;
      wheel_r = hwgrb_pkg::WHEEL_SEG3_BASE - pend_hue_r;
    end
  end

  // Select raw bytes or scaled wheel color
  always_comb begin
    if (pend_mode_r == hwgrb_pkg::MODE_HUE) begin
      pix_g = scale_chan(wheel_g, pend_brt_r);
      pix_r = scale_chan(wheel_r, pend_brt_r);
      pix_b = scale_chan(wheel_b, pend_brt_r);
    end else begin
      pix_g = pend_g_r;
      pix_r = pend_r_r;
      pix_b = pend_b_r;
    end
  end

  // Next-state logic for the pending slot and the shifter
  always_comb begin
    pend_vld_nxt = pend_vld_r;
    if (in_take) begin
      pend_vld_nxt = 1'b1;
    end else if (load) begin
      pend_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    shift_nxt   = shift_r;
    idx_nxt     = idx_r;
    if (load) begin
      out_vld_nxt = 1'b1;
      shift_nxt   = {pix_g, pix_r, pix_b};
      idx_nxt     = '0;
    end else if (out_take) begin
      // Advance one bit; drop valid after the last one
      shift_nxt = shift_r << 1;
      idx_nxt   = idx_r + 1'b1;
      if (shift_done) begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      pend_mode_r <= in_ch.mode;
      pend_g_r    <= in_ch.green_in;
      pend_r_r    <= in_ch.red_in;
      pend_b_r    <= in_ch.blue_in;
      pend_hue_r  <= in_ch.hue;
      pend_brt_r  <= in_ch.brightness;
    end
    shift_r <= shift_nxt;
    idx_r   <= idx_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.bit_value = shift_r[hwgrb_pkg::PIXEL_BITS-1];
  assign out_ch.last      = (idx_r == hwgrb_pkg::LAST_BIT_IDX);

  // A reload always starts a fresh pixel at its first bit
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_vld_r && idx_r == '0))
    else $error("shifter reload did not start at bit zero");

  // A pixel never stops before its last bit
  a_no_early_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !shift_done) |=> out_vld_r)
    else $error("output dropped in the middle of a pixel");

  // After the last bit with nothing pending, the shifter goes empty
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (shift_done && !load) |=> !out_vld_r)
    else $error("output still valid after last bit");

  // A pending pixel is held until loaded
  a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_vld_r && !load) |=> pend_vld_r)
    else $error("pending pixel lost before load");

  // Bit index never runs past the end of the pixel
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (idx_r <= hwgrb_pkg::LAST_BIT_IDX))
    else $error("bit index out of range");

endmodule
